// ----- src/dpq_pkg.sv -----
`default_nettype none
package dpq_pkg;
  localparam int DefCapacity = 1023;
  localparam int DefKeyWidth = 32;
  localparam int ValueWidth = 32;
  localparam int SizeWidth = 10;
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqDelete = 1'b1;
endpackage
`default_nettype wire

// ----- src/dpq_ram.sv -----
`default_nettype none
module dpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/deap_priority_queue_top.sv -----
`default_nettype none
// Double-ended priority queue kept as a deap in one single-port-read RAM:
// position 1 roots a min-heap and position 2 a max-heap. Each request
// (insert a key, or delete the minimum) answers with one response carrying
// the minimum, maximum, count and flags. A request occupies the block until
// its response is taken, walking the tree one level at a time: one RAM read
// is issued per cycle and its registered data is compared in the next. A
// delete walks the hole down the min-heap, and the last key then climbs
// from where the hole stops, as an inserted key climbs. The root keys are
// read back from the RAM at the end of every request, and the response then
// waits for out_ready. No clearing pass is needed after reset.
module deap_priority_queue_top
  import dpq_pkg::*;
#(
  parameter int CAPACITY  = DefCapacity,
  parameter int KEY_WIDTH = DefKeyWidth
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  req_type,
  input  wire logic [ValueWidth-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ValueWidth-1:0]      min_value,
  output logic [ValueWidth-1:0]      max_value,
  output logic [SizeWidth-1:0]       size_now,
  output logic                       empty_flag,
  output logic                       error_flag
);
  localparam int AW = $clog2(CAPACITY + 1);
  localparam int CW = AW + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DRD   = 12'b000000000010, // read left child of hole
    S_DCMP  = 12'b000000000100, // latch left child, read right child; move an only child into hole
    S_DRD2  = 12'b000000001000, // pick smaller child, move it into hole
    S_PLACE = 12'b000000010000, // compute mate, read it
    S_MCMP  = 12'b000000100000, // partner compare
    S_UPRD  = 12'b000001000000, // read parent
    S_UPCMP = 12'b000010000000, // compare with parent
    S_RMIN  = 12'b000100000000,
    S_RMAX  = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [KEY_WIDTH-1:0] key, lkey;
  logic [AW-1:0] pos, hole;
  logic upmax, err, lastrd;
  logic [KEY_WIDTH-1:0] lmin;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_WIDTH-1:0] wdata, rdata;

  dpq_ram #(.Width(KEY_WIDTH), .Depth(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Level span: largest power of two not above pos+1.
  function automatic logic [CW-1:0] span(input logic [AW-1:0] p);
    logic [CW-1:0] v, r;
    v = CW'(p) + CW'(1);
    r = '0;
    for (int i = 0; i < CW; i++) if (v[i]) r = CW'(1) << i;
    return r;
  endfunction

  logic [CW-1:0] sp;
  logic minside;
  logic [CW-1:0] mate_hi, mate_lo;
  always_comb begin
    sp = span(pos);
    minside = (CW'(pos) + CW'(1)) < (sp + (sp >> 1));
    mate_hi = CW'(pos) + (sp >> 1);
    mate_lo = CW'(pos) - (sp >> 1);
  end

  logic [CW-1:0] lc, rc;
  assign lc = {hole, 1'b1};
  assign rc = {hole, 1'b0} + CW'(2);
  logic [AW-1:0] parent;
  assign parent = AW'((CW'(pos) - CW'(1)) >> 1);

  logic [KEY_WIDTH-1:0] kin;
  assign kin = KEY_WIDTH'($signed(value));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          if (req_type == ReqInsert) begin
            if (count >= CW'(CAPACITY)) begin
              err <= 1'b1; state <= S_RMIN;
            end else if (count == '0) begin
              err <= 1'b0; count <= CW'(1); state <= S_RMIN;
            end else begin
              err <= 1'b0; count <= count + CW'(1);
              pos <= AW'(count + CW'(1)); key <= kin; state <= S_PLACE;
            end
          end else begin
            if (count == '0) begin
              err <= 1'b1; state <= S_RMIN;
            end else if (count <= CW'(2)) begin
              err <= 1'b0;
              count <= count - CW'(1); state <= S_PLACE; lastrd <= 1'b1;
              pos <= AW'(1);
            end else begin
              err <= 1'b0;
              count <= count - CW'(1); hole <= AW'(1); lastrd <= 1'b0;
              state <= S_DRD;
            end
          end
        end
        S_DRD: begin
          // rdata here = last key (read issued in IDLE) on first pass
          if (!lastrd) begin lkey <= rdata; lastrd <= 1'b1; end
          if (lc > count) begin
            key <= lastrd ? lkey : rdata; pos <= hole;
            state <= (hole < AW'(2)) ? S_RMIN : S_PLACE;
          end else state <= S_DCMP;
        end
        S_DCMP: begin
          lmin <= rdata;
          if (rc <= count) state <= S_DRD2;
          else begin hole <= AW'(lc); state <= S_DRD; end
        end
        S_DRD2: begin
          if ($signed(rdata) < $signed(lmin)) hole <= AW'(rc);
          else hole <= AW'(lc);
          state <= S_DRD;
        end
        S_PLACE: begin
          if (pos == AW'(1)) begin
            // short delete: rdata is the last key; pos 1 is written here if one key remains
            state <= S_RMIN;
          end else state <= S_MCMP;
        end
        S_MCMP: begin
          if (minside) begin
            if ($signed(key) > $signed(rdata)) begin
              upmax <= 1'b1;
              pos <= (mate_hi > count) ? AW'((mate_hi - CW'(1)) >> 1) : AW'(mate_hi);
            end else upmax <= 1'b0;
          end else begin
            if ($signed(key) < $signed(rdata)) begin
              upmax <= 1'b0; pos <= AW'(mate_lo);
            end else upmax <= 1'b1;
          end
          state <= S_UPRD;
        end
        S_UPRD: begin
          if ((upmax && pos > AW'(2)) || (!upmax && pos > AW'(1))) state <= S_UPCMP;
          else state <= S_RMIN;
        end
        S_UPCMP: begin
          if (upmax ? ($signed(key) > $signed(rdata)) : ($signed(key) < $signed(rdata))) begin
            pos <= parent; state <= S_UPRD;
          end else state <= S_RMIN;
        end
        S_RMIN: state <= S_RMAX;
        S_RMAX: begin
          min_value <= (count == '0) ? '0 : ValueWidth'($signed(rdata));
          state <= S_FIN;
        end
        S_FIN: begin
          // With fewer than two keys the maximum is the minimum (or zero).
          if (count >= CW'(2)) max_value <= ValueWidth'($signed(rdata));
          else max_value <= min_value;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // RAM control. Writes: first key, child moves into the hole, parent/mate moves, final key placement.
  logic up_done;
  always_comb begin
    we = 1'b0; waddr = pos; wdata = key; raddr = pos;
    up_done = 1'b0;
    case (state)
      S_IDLE: begin
        raddr = AW'(count);
        if (in_valid && req_type == ReqInsert && count == '0) begin
          we = 1'b1; waddr = AW'(1); wdata = kin;
        end
      end
      S_DRD: begin
        raddr = AW'(lc);
        if (lc > count && hole < AW'(2)) begin
          we = 1'b1; waddr = AW'(1); wdata = lastrd ? lkey : rdata;
        end
      end
      S_DCMP: begin
        raddr = AW'(rc);
        // Only a left child: it moves up into the hole right away.
        if (rc > count) begin
          we = 1'b1; waddr = hole; wdata = rdata;
        end
      end
      S_DRD2: begin
        we = 1'b1; waddr = hole;
        wdata = ($signed(rdata) < $signed(lmin)) ? rdata : lmin;
      end
      S_PLACE: begin
        if (pos == AW'(1)) begin
          we = (count == CW'(1)); waddr = AW'(1); wdata = rdata;
        end else if (minside) raddr = (mate_hi > count) ? AW'((mate_hi - CW'(1)) >> 1)
                                                       : AW'(mate_hi);
        else raddr = AW'(mate_lo);
      end
      S_MCMP: begin
        if (minside ? ($signed(key) > $signed(rdata)) : ($signed(key) < $signed(rdata))) begin
          we = 1'b1; waddr = pos; wdata = rdata;
        end
      end
      S_UPRD: begin
        raddr = parent;
        if (!((upmax && pos > AW'(2)) || (!upmax && pos > AW'(1)))) begin
          we = 1'b1; waddr = pos; wdata = key;
        end
      end
      S_UPCMP: begin
        we = 1'b1; waddr = pos;
        up_done = !(upmax ? ($signed(key) > $signed(rdata)) : ($signed(key) < $signed(rdata)));
        wdata = up_done ? key : rdata;
      end
      S_RMIN: raddr = AW'(1);
      S_RMAX: raddr = AW'(2);
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign size_now = SizeWidth'(count);
  assign empty_flag = (count == '0);
  assign error_flag = err;

  // The count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count above capacity");
  // A response is offered only after the root keys were read back.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("response without read of roots");
  // The count changes only when a request is accepted.
  assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid && in_ready) |-> $stable(count))
    else $error("count moved while busy");
endmodule
`default_nettype wire

// ----- bench/tb_deap_priority_queue_top.sv -----
`default_nettype none
module tb_deap_priority_queue_top;
  import dpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity   = DefCapacity;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic                  hold;
    logic                  kind;
    logic [ValueWidth-1:0] key;
  } request_t;

  typedef struct packed {
    logic [ValueWidth-1:0] lo;
    logic [ValueWidth-1:0] hi;
    logic [SizeWidth-1:0]  count;
    logic                  empty;
    logic                  refused;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = ReqInsert;
  logic [ValueWidth-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ValueWidth-1:0] min_value, max_value;
  logic [SizeWidth-1:0] size_now;
  logic empty_flag, error_flag;

  request_t pending_reqs[$];
  status_t  expected_status[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       stim_done = 1'b0;
  bit       no_idle = 1'b0;

  // Shadow deap: keys at positions 1..key_total.
  int heap_keys[0:Capacity];
  int key_total = 0;

  deap_priority_queue_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .min_value(min_value), .max_value(max_value), .size_now(size_now),
    .empty_flag(empty_flag), .error_flag(error_flag)
  );

  always #10 clk = ~clk;

  function automatic int span_of(int pos);
    int p;
    p = 1;
    while (p <= (pos + 1) / 2) p = p * 2;
    return p;
  endfunction

  function automatic void lift_min(int pos, int k);
    while (pos > 1 && k < heap_keys[(pos - 1) / 2]) begin
      heap_keys[pos] = heap_keys[(pos - 1) / 2];
      pos = (pos - 1) / 2;
    end
    heap_keys[pos] = k;
  endfunction

  function automatic void lift_max(int pos, int k);
    while (pos > 2 && k > heap_keys[(pos - 1) / 2]) begin
      heap_keys[pos] = heap_keys[(pos - 1) / 2];
      pos = (pos - 1) / 2;
    end
    heap_keys[pos] = k;
  endfunction

  // Put k at pos after comparing it with the partner node in the other heap.
  function automatic void settle(int pos, int k);
    int p, mate;
    p = span_of(pos);
    if (pos < p - 1 + p / 2) begin
      mate = pos + p / 2;
      if (mate > key_total) mate = (mate - 1) / 2;
      if (k > heap_keys[mate]) begin
        heap_keys[pos] = heap_keys[mate];
        lift_max(mate, k);
      end else begin
        lift_min(pos, k);
      end
    end else begin
      mate = pos - p / 2;
      if (k < heap_keys[mate]) begin
        heap_keys[pos] = heap_keys[mate];
        lift_min(mate, k);
      end else begin
        lift_max(pos, k);
      end
    end
  endfunction

  function automatic status_t deap_apply(request_t r);
    status_t s;
    int last, hole, l, rt;
    s = '0;
    if (r.kind == ReqInsert) begin
      if (key_total >= Capacity) begin
        s.refused = 1'b1;
      end else begin
        key_total++;
        if (key_total == 1) heap_keys[1] = r.key;
        else settle(key_total, r.key);
      end
    end else if (key_total == 0) begin
      s.refused = 1'b1;
    end else if (key_total <= 2) begin
      last = heap_keys[key_total];
      key_total--;
      if (key_total == 1) heap_keys[1] = last;
    end else begin
      last = heap_keys[key_total];
      key_total--;
      hole = 1;
      forever begin
        l = 2 * hole + 1;
        rt = 2 * hole + 2;
        if (rt <= key_total && heap_keys[rt] < heap_keys[l]) begin
          heap_keys[hole] = heap_keys[rt];
          hole = rt;
        end else if (l <= key_total) begin
          heap_keys[hole] = heap_keys[l];
          hole = l;
        end else begin
          break;
        end
      end
      if (hole < 2) heap_keys[1] = last;
      else settle(hole, last);
    end
    if (key_total >= 1) begin
      s.lo = heap_keys[1];
      s.hi = key_total >= 2 ? heap_keys[2] : heap_keys[1];
    end
    s.count = key_total[SizeWidth-1:0];
    s.empty = key_total == 0;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValueWidth-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic hold, logic kind, logic [ValueWidth-1:0] key);
    request_t r;
    r.hold = hold;
    r.kind = kind;
    r.key = key;
    pending_reqs = {pending_reqs, r};
  endtask

  // Driver: valid is assigned exactly once per edge.
  always @(posedge clk) begin
    logic fired;
    request_t r;
    status_t st;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fired = in_valid && in_ready;
      if (fired) begin
        r.hold = 1'b0;
        r.kind = req_type;
        r.key = value;
        st = deap_apply(r);
        expected_status = {expected_status, st};
        send_gap = pick_gap();
      end
      if (in_valid && !fired) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (!pending_reqs[0].hold || (!fired && expected_status.size() == 0))) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= r.kind;
        value <= r.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and response-side stalls.
  always @(posedge clk) begin
    status_t want, got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{lo: min_value, hi: max_value, count: size_now,
                empty: empty_flag, refused: error_flag};
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected response %h", $realtime, got);
          errors++;
        end else begin
          want = expected_status.pop_front();
          if (got.lo !== want.lo)
            $display("%0t: min_value expected %h actual %h", $realtime, want.lo, got.lo);
          if (got.hi !== want.hi)
            $display("%0t: max_value expected %h actual %h", $realtime, want.hi, got.hi);
          if (got.count !== want.count)
            $display("%0t: size_now expected %0d actual %0d", $realtime, want.count, got.count);
          if (got.empty !== want.empty)
            $display("%0t: empty_flag expected %b actual %b", $realtime, want.empty, got.empty);
          if (got.refused !== want.refused)
            $display("%0t: error_flag expected %b actual %b", $realtime, want.refused, got.refused);
          if (got !== want) errors++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Directed: empty delete, extremes, duplicates, single key, shrink to empty.
    add_req(1'b0, ReqDelete, 32'hFFFF_FFFF);
    add_req(1'b0, ReqInsert, 32'h7FFF_FFFF);
    add_req(1'b0, ReqDelete, '0);
    add_req(1'b0, ReqInsert, 32'h8000_0000);
    add_req(1'b0, ReqInsert, 32'h7FFF_FFFF);
    add_req(1'b0, ReqInsert, 32'h0000_0000);
    add_req(1'b0, ReqInsert, 32'hFFFF_FFFF);
    add_req(1'b0, ReqInsert, 32'h0000_0001);
    add_req(1'b0, ReqInsert, 32'h0000_0001);
    add_req(1'b0, ReqInsert, 32'h5555_5555);
    add_req(1'b0, ReqInsert, 32'hAAAA_AAAA);
    repeat (10) add_req(1'b0, ReqDelete, '0);
    add_req(1'b0, ReqInsert, 32'h0000_0007);
    add_req(1'b0, ReqDelete, '0);

    // Random mix, mostly inserts so the tree gets several levels deep.
    no_idle = 1'b0;
    for (int i = 0; i < 360; i++) begin
      if ($urandom_range(0, 99) < 62) begin
        add_req(i == 180, ReqInsert, pick_key());
      end else begin
        add_req(i == 180, ReqDelete, $urandom);
      end
    end

    // Drain a little, then put the extremes back in.
    repeat (15) add_req(1'b0, ReqDelete, '0);
    add_req(1'b0, ReqInsert, 32'h8000_0000);
    add_req(1'b0, ReqInsert, 32'h7FFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() < 250);
    no_idle = 1'b1;
    wait (pending_reqs.size() < 120);
    no_idle = 1'b0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_status.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- deap_priority_queue_top.f -----
src/dpq_pkg.sv
src/dpq_ram.sv
src/deap_priority_queue_top.sv
bench/tb_deap_priority_queue_top.sv
